[hw/rtl/dgemb_pkg.sv]
package dgemb_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int LINE_DEPTH = 2 * MAX_WIDTH + 2;

  // register field widths
  localparam int CFG_WIDTH_BITS  = 12;
  localparam int CFG_HEIGHT_BITS = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int RESET_WIDTH     = 640;
  localparam int RESET_HEIGHT    = 480;

  localparam int WW  = $clog2(MAX_WIDTH + 1);   // effective width
  localparam int CW  = $clog2(MAX_WIDTH);       // column
  localparam int HW  = $clog2(MAX_HEIGHT + 1);  // effective height
  localparam int RW  = $clog2(MAX_HEIGHT);      // row
  localparam int PW  = $clog2(MAX_WIDTH + 2);   // pending count
  localparam int AW  = $clog2(LINE_DEPTH);      // delay line address
  localparam int GW  = $clog2(LINE_DEPTH + 1);  // pixel age
  localparam int AXW = ((AW > GW) ? AW : GW) + 1;

  localparam int CHAN_BITS   = 8;
  localparam int PIX_BITS    = 4 * CHAN_BITS;
  localparam int COLOR_BITS  = 3 * CHAN_BITS;
  localparam int EMBOSS_BIAS = 128;
  localparam int CHAN_MAX    = 255;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

  typedef logic [PIX_BITS-1:0] pixel_t;

  typedef struct packed {
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    pixel_t                wr_data;
    logic                  rd_en;
    logic [AW-1:0]         cen_addr;
    logic [AW-1:0]         ul_addr;
    logic [AW-1:0]         lr_addr;
  } mem_req_t;

  typedef struct packed {
    pixel_t cen;
    pixel_t ul;
    pixel_t lr;
  } mem_rsp_t;

  typedef struct packed {
    logic                  vld;
    logic                  use_inc;
    logic                  emboss;
    logic                  last;
    logic [COLOR_BITS-1:0] inc;
  } issue_t;

  function automatic logic [WW-1:0] clamp_width(input logic [CFG_WIDTH_BITS-1:0] v);
    if (v == '0) begin
      return WW'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      return WW'(MAX_WIDTH);
    end else begin
      return WW'(v);
    end
  endfunction

  function automatic logic [HW-1:0] clamp_height(input logic [CFG_HEIGHT_BITS-1:0] v);
    if (v == '0) begin
      return HW'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      return HW'(MAX_HEIGHT);
    end else begin
      return HW'(v);
    end
  endfunction

  // address of the stored pixel of the given age, 1 = newest
  function automatic logic [AW-1:0] age_addr(input logic [AW-1:0] wr, input logic [GW-1:0] age);
    logic [AXW-1:0] w_x;
    logic [AXW-1:0] a_x;
    w_x = AXW'(wr);
    a_x = AXW'(age);
    if (w_x >= a_x) begin
      return AW'(w_x - a_x);
    end else begin
      return AW'(w_x + AXW'(LINE_DEPTH) - a_x);
    end
  endfunction

  function automatic logic [CHAN_BITS-1:0] sat_chan(input logic [CHAN_BITS-1:0] lr,
                                                    input logic [CHAN_BITS-1:0] ul);
    logic signed [CHAN_BITS+1:0] v;
    v = $signed({2'b00, lr}) - $signed({2'b00, ul}) + $signed((CHAN_BITS + 2)'(EMBOSS_BIAS));
    if (v < $signed((CHAN_BITS + 2)'(0))) begin
      return '0;
    end else if (v > $signed((CHAN_BITS + 2)'(CHAN_MAX))) begin
      return CHAN_BITS'(CHAN_MAX);
    end else begin
      return v[CHAN_BITS-1:0];
    end
  endfunction

endpackage

[hw/rtl/dgemb_line_mem.sv]
module dgemb_line_mem (
  input  logic                clk,
  input  dgemb_pkg::mem_req_t req,
  output dgemb_pkg::mem_rsp_t rsp
);

  // two copies of the delay line give three read ports
  dgemb_pkg::pixel_t mem_a [dgemb_pkg::LINE_DEPTH];
  dgemb_pkg::pixel_t mem_b [dgemb_pkg::LINE_DEPTH];

  dgemb_pkg::pixel_t cen_r;
  dgemb_pkg::pixel_t ul_r;
  dgemb_pkg::pixel_t lr_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_a[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      cen_r <= mem_a[req.cen_addr];
      ul_r  <= mem_a[req.ul_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_b[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      lr_r <= mem_b[req.lr_addr];
    end
  end

  assign rsp.cen = cen_r;
  assign rsp.ul  = ul_r;
  assign rsp.lr  = lr_r;

endmodule

[hw/rtl/dgemb_ctrl.sv]
module dgemb_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [0:0]                           cfg_index,
  input  logic [dgemb_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic                                 in_tuser,
  input  logic [dgemb_pkg::PIX_BITS-1:0]       in_tdata,
  input  logic                                 s1_ready,
  output dgemb_pkg::issue_t                    iss,
  output dgemb_pkg::mem_req_t                  mreq
);

  logic [dgemb_pkg::WW-1:0] width_r;
  logic [dgemb_pkg::HW-1:0] height_r;
  logic [dgemb_pkg::PW-1:0] pend_r,   pend_nxt;
  logic [dgemb_pkg::AW-1:0] wr_pos_r, wr_pos_nxt;
  logic [dgemb_pkg::CW-1:0] col_r,    col_nxt;
  logic [dgemb_pkg::RW-1:0] row_r,    row_nxt;

  logic                     accept;
  logic                     flush;
  logic [dgemb_pkg::GW-1:0] w1;
  logic [dgemb_pkg::GW-1:0] p_x;
  logic                     emit_px;
  logic                     emit_fl;
  logic                     emit;
  logic                     use_inc;
  logic                     have_lr;
  logic [dgemb_pkg::WW-1:0] col1;
  logic [dgemb_pkg::HW-1:0] row1;
  logic                     col_end;
  logic                     row_end;
  logic                     interior;

  assign cfg_ready = 1'b1;
  assign in_tready = s1_ready;
  assign accept    = in_tvalid && s1_ready;
  assign flush     = in_tuser;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= dgemb_pkg::clamp_width(dgemb_pkg::CFG_WIDTH_BITS'(dgemb_pkg::RESET_WIDTH));
      height_r <= dgemb_pkg::clamp_height(dgemb_pkg::CFG_HEIGHT_BITS'(dgemb_pkg::RESET_HEIGHT));
    end else if (cfg_valid) begin
      unique case (dgemb_pkg::cfg_reg_t'(cfg_index))
        dgemb_pkg::REG_FRAME_WIDTH: begin
          width_r <= dgemb_pkg::clamp_width(cfg_data[dgemb_pkg::CFG_WIDTH_BITS-1:0]);
        end
        dgemb_pkg::REG_FRAME_HEIGHT: begin
          height_r <= dgemb_pkg::clamp_height(cfg_data[dgemb_pkg::CFG_HEIGHT_BITS-1:0]);
        end
      endcase
    end
  end

  always_comb begin
    w1       = dgemb_pkg::GW'(width_r) + dgemb_pkg::GW'(1);
    p_x      = dgemb_pkg::GW'(pend_r);
    emit_px  = !flush && (p_x >= w1);
    emit_fl  = flush && (pend_r != '0);
    emit     = emit_px || emit_fl;
    // lower-right neighbor is the incoming word when it is exactly one line plus one pixel on
    use_inc  = !flush && (p_x == w1);
    have_lr  = use_inc || (p_x > w1);
    col1     = dgemb_pkg::WW'(col_r) + dgemb_pkg::WW'(1);
    row1     = dgemb_pkg::HW'(row_r) + dgemb_pkg::HW'(1);
    col_end  = col1 >= width_r;
    row_end  = row1 >= height_r;
    interior = (col_r != '0) && !col_end && (row_r != '0) && !row_end;
  end

  always_comb begin
    pend_nxt   = pend_r;
    wr_pos_nxt = wr_pos_r;
    col_nxt    = col_r;
    row_nxt    = row_r;
    if (accept) begin
      if (!flush) begin
        wr_pos_nxt = (wr_pos_r == dgemb_pkg::AW'(dgemb_pkg::LINE_DEPTH - 1)) ?
                     '0 : wr_pos_r + dgemb_pkg::AW'(1);
        if (!emit_px) begin
          pend_nxt = pend_r + dgemb_pkg::PW'(1);
        end
      end else if (emit_fl) begin
        pend_nxt = pend_r - dgemb_pkg::PW'(1);
      end
      if (emit) begin
        if (col_end) begin
          col_nxt = '0;
          row_nxt = row_end ? '0 : dgemb_pkg::RW'(row1);
        end else begin
          col_nxt = dgemb_pkg::CW'(col1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r   <= '0;
      wr_pos_r <= '0;
      col_r    <= '0;
      row_r    <= '0;
    end else begin
      pend_r   <= pend_nxt;
      wr_pos_r <= wr_pos_nxt;
      col_r    <= col_nxt;
      row_r    <= row_nxt;
    end
  end

  always_comb begin
    mreq.wr_en    = accept && !flush;
    mreq.wr_addr  = wr_pos_r;
    mreq.wr_data  = in_tdata;
    mreq.rd_en    = accept && emit;
    mreq.cen_addr = dgemb_pkg::age_addr(wr_pos_r, p_x);
    mreq.ul_addr  = dgemb_pkg::age_addr(wr_pos_r, p_x + w1);
    mreq.lr_addr  = dgemb_pkg::age_addr(wr_pos_r, p_x - w1);

    iss.vld     = accept && emit;
    iss.use_inc = use_inc;
    iss.emboss  = interior && have_lr;
    iss.last    = col_end && row_end;
    iss.inc     = in_tdata[dgemb_pkg::COLOR_BITS-1:0];
  end

`ifndef ASSERT_OFF
  a_wr_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pos_r <= dgemb_pkg::AW'(dgemb_pkg::LINE_DEPTH - 1))
    else $error("delay line write pointer out of range");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= dgemb_pkg::PW'(dgemb_pkg::MAX_WIDTH + 1))
    else $error("pending count beyond one line plus one pixel");

  a_issue_accepted: assert property (@(posedge clk) disable iff (!rst_n)
    iss.vld |-> in_tvalid && s1_ready)
    else $error("result issued without an accepted word");

  a_px_emit_holds_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && emit_px) |=> $stable(pend_r))
    else $error("pending count moved on a pixel that produced a result");
`endif

endmodule

[hw/rtl/dgemb_calc.sv]
module dgemb_calc (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dgemb_pkg::issue_t               iss,
  input  dgemb_pkg::mem_rsp_t             rsp,
  output logic                            s1_ready,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [dgemb_pkg::PIX_BITS-1:0]  out_tdata,
  output logic                            out_tlast
);

  logic                                s1_vld_r,  s1_vld_nxt;
  logic                                out_vld_r, out_vld_nxt;
  logic                                use_inc_r;
  logic                                emboss_r;
  logic                                last_r;
  logic [dgemb_pkg::COLOR_BITS-1:0]    inc_r;
  dgemb_pkg::pixel_t                   out_data_r;
  logic                                out_last_r;

  logic                                adv_out;
  logic [dgemb_pkg::COLOR_BITS-1:0]    lr;
  dgemb_pkg::pixel_t                   res;

  assign adv_out  = s1_vld_r && (!out_vld_r || out_tready);
  assign s1_ready = !s1_vld_r || adv_out;

  always_comb begin
    s1_vld_nxt  = iss.vld ? 1'b1 : (adv_out ? 1'b0 : s1_vld_r);
    out_vld_nxt = adv_out ? 1'b1 : (out_tready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (iss.vld) begin
      use_inc_r <= iss.use_inc;
      emboss_r  <= iss.emboss;
      last_r    <= iss.last;
      inc_r     <= iss.inc;
    end
  end

  always_comb begin
    lr  = use_inc_r ? inc_r : rsp.lr[dgemb_pkg::COLOR_BITS-1:0];
    res = rsp.cen;
    if (emboss_r) begin
      for (int c = 0; c < 3; c++) begin
        res[c*dgemb_pkg::CHAN_BITS +: dgemb_pkg::CHAN_BITS] =
          dgemb_pkg::sat_chan(lr[c*dgemb_pkg::CHAN_BITS +: dgemb_pkg::CHAN_BITS],
                              rsp.ul[c*dgemb_pkg::CHAN_BITS +: dgemb_pkg::CHAN_BITS]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      out_data_r <= res;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

[hw/rtl/diagonal_emboss_stream.sv]
// Diagonal emboss over a raster-order stream of BGRA pixels.
// Input channel in_*: one word per pixel, tdata = {alpha, red, green, blue} with blue
// in the low byte; tuser high marks a flush word that carries no pixel and only drains.
// Output channel out_*: one pixel per word in the same packing (interior pixels embossed,
// border pixels passed through), tlast on the final pixel of each frame. Results trail the
// input by one line plus one pixel: a pixel is read when its lower-right neighbor is taken,
// then leaves through the read stage and the output register. After the last frame, width+1
// flush words drain the remaining pixels; a flush with nothing pending produces no output word.
// Configuration: cfg_index 0 = frame width, 1 = frame height, written with cfg_valid
// (cfg_ready is always high) while the stream is idle.
// Throughput is one word per cycle while out_tready is high; the delay line is duplicated
// in two memories so the center, upper-left and lower-right reads all issue in the accepting cycle.
// Reset clears the position and pending counters, restores 640 x 480 and leaves the
// delay line contents undefined; no clearing pass is needed.
// When out_tready is low the output register holds, the read stage behind it fills,
// and in_tready drops until the output word is taken.
module diagonal_emboss_stream (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [0:0]                          cfg_index,
  input  logic [dgemb_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [dgemb_pkg::PIX_BITS-1:0]      in_tdata,   // blue_in, green_in, red_in, alpha_in
  input  logic                                in_tuser,   // flush
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [dgemb_pkg::PIX_BITS-1:0]      out_tdata,  // blue_out, green_out, red_out, alpha_out
  output logic                                out_tlast
);

  dgemb_pkg::issue_t   iss;
  dgemb_pkg::mem_req_t mreq;
  dgemb_pkg::mem_rsp_t mrsp;
  logic                s1_ready;

  dgemb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .s1_ready  (s1_ready),
    .iss       (iss),
    .mreq      (mreq)
  );

  dgemb_line_mem u_line_mem (
    .clk (clk),
    .req (mreq),
    .rsp (mrsp)
  );

  dgemb_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .iss        (iss),
    .rsp        (mrsp),
    .s1_ready   (s1_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
